/* rtl/core/mlfq_pkg.sv */
// Package of shared types and constants for the feedback queue scheduler.
`default_nettype none

package mlfq_pkg;

    // Fixed field widths of the ports.
    localparam int SLICE_W    = 16;
    localparam int ELAPSED_W  = 21;
    localparam int JOB_NUM_W  = 6;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_ONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TWO = 1'd1;

    // Reset values of the slices.
    localparam logic [SLICE_W-1:0] SLICE_ONE_RST = 16'd4;
    localparam logic [SLICE_W-1:0] SLICE_TWO_RST = 16'd8;

    // Queue level codes, as reported on the finish level output.
    localparam logic [LEVEL_W-1:0] LVL_ONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_TWO   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_THREE = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/multilevel_feedback_queue_scheduler_unit.sv */
// Top level of the three-level feedback queue scheduler.
//
// Usage: each transfer on the input channel (i_in_valid / o_in_stall) loads one
// job burst time; jobs are numbered from 1 in arrival order and at most
// MAX_JOBS are held, later ones being dropped. A non-final item gives no
// result. The item with i_final_job set is loaded too and then the set is
// scheduled: level one and level two are round robin with their configured
// slices, a job that outlives its slice drops one level, and level three
// runs jobs to the end. Each completion is one transfer on the output
// channel (o_out_valid / i_out_stall) carrying the job number, finish time
// and level; o_last_result marks the final completion.
// Every visit of a job to a level is a level store read (ST_READ), then one
// pass through the shared compare/subtract unit and the time adder (ST_EXEC);
// a level change takes one more pass through ST_READ. A stalled receiver
// holds the result register and the walk waits on the next completion.
// Reset clears the job set, the pointers, the elapsed time and the output
// valid, and returns both slices to their default values (4 and 8). The set
// is cleared again after each schedule; the slices are kept.
`default_nettype none

module multilevel_feedback_queue_scheduler_unit #(
    parameter int MAX_JOBS   = 32,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [TIME_WIDTH-1:0]              i_burst_time,
    input  wire logic                               i_final_job,
    // Result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [mlfq_pkg::JOB_NUM_W-1:0]          o_job_number,
    output logic [mlfq_pkg::ELAPSED_W-1:0]          o_finish_time,
    output logic [mlfq_pkg::LEVEL_W-1:0]            o_finish_level,
    output logic                                    o_last_result,
    // Configuration port
    input  wire logic                               i_cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import mlfq_pkg::*;

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int RW = (TIME_WIDTH > SLICE_W) ? TIME_WIDTH : SLICE_W;
    localparam int SW = (RW > ELAPSED_W) ? RW : ELAPSED_W;
    localparam int EW = CW + RW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_JOBS);

    // Control registers.
    t_state              r_state,   n_state;
    logic [LEVEL_W-1:0]  r_level,   n_level;
    logic [CW-1:0]       r_idx,     n_idx;
    logic [CW-1:0]       r_cnt1,    n_cnt1;
    logic [CW-1:0]       r_cnt2,    n_cnt2;
    logic [CW-1:0]       r_cnt3,    n_cnt3;
    logic [CW-1:0]       r_done,    n_done;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [SLICE_W-1:0]  r_slice1;
    logic [SLICE_W-1:0]  r_slice2;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic                out_load;
    logic [JOB_NUM_W-1:0] r_job_number;
    logic [ELAPSED_W-1:0] r_finish_time;
    logic [LEVEL_W-1:0]  r_finish_level;
    logic                r_last_result;

    // Level store ports.
    logic          we1, we2, we3;
    logic [AW-1:0] waddr1, waddr2, waddr3;
    logic [EW-1:0] wdata1, wdata_next;
    logic          re1, re2, re3;
    logic [EW-1:0] rdata1, rdata2, rdata3;

    // Shared unit signals.
    logic [EW-1:0]  entry;
    logic [CW-1:0]  entry_id;
    logic [RW-1:0]  entry_remain;
    logic [SLICE_W-1:0] slice_sel;
    logic [RW:0]    diff;
    logic           outlives;
    logic [RW-1:0]  run_time;
    logic [SW-1:0]  time_sum;
    logic [CW+JOB_NUM_W-1:0] id_ext;
    logic [CW-1:0]  cur_cnt;
    logic           accept;

    mlfq_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_level_one (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_re    (re1),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata1)
    );

    mlfq_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_level_two (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (waddr2),
        .i_wdata (wdata_next),
        .i_re    (re2),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata2)
    );

    mlfq_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_level_three (
        .i_clk   (i_clk),
        .i_we    (we3),
        .i_waddr (waddr3),
        .i_wdata (wdata_next),
        .i_re    (re3),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata3)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // Loading port of the level one store.
    assign waddr1 = r_cnt1[AW-1:0];
    assign wdata1 = {r_cnt1 + CW'(1), RW'(i_burst_time)};
    assign waddr2 = r_cnt2[AW-1:0];
    assign waddr3 = r_cnt3[AW-1:0];

    // Selection of the current level's entry, slice and fill count.
    always_comb begin
        entry     = rdata1;
        slice_sel = r_slice1;
        cur_cnt   = r_cnt1;
        unique case (r_level)
            LVL_ONE: begin
                entry     = rdata1;
                slice_sel = r_slice1;
                cur_cnt   = r_cnt1;
            end
            LVL_TWO: begin
                entry     = rdata2;
                slice_sel = r_slice2;
                cur_cnt   = r_cnt2;
            end
            LVL_THREE: begin
                entry   = rdata3;
                cur_cnt = r_cnt3;
            end
            default: begin
                entry   = rdata3;
                cur_cnt = r_cnt3;
            end
        endcase
    end

    // Shared compare/subtract unit and the elapsed time adder.
    assign entry_id     = entry[EW-1:RW];
    assign entry_remain = entry[RW-1:0];
    assign diff         = {1'b0, entry_remain} - (RW + 1)'(slice_sel);
    assign outlives     = (r_level != LVL_THREE) && !diff[RW] && (|diff[RW-1:0]);
    assign run_time     = outlives ? RW'(slice_sel) : entry_remain;
    assign time_sum     = SW'(r_elapsed) + SW'(run_time);
    assign wdata_next   = {entry_id, diff[RW-1:0]};
    assign id_ext       = {{JOB_NUM_W{1'b0}}, entry_id};

    // Sequencer: next state, store controls and result loading.
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_idx       = r_idx;
        n_cnt1      = r_cnt1;
        n_cnt2      = r_cnt2;
        n_cnt3      = r_cnt3;
        n_done      = r_done;
        n_elapsed   = r_elapsed;
        we1         = 1'b0;
        we2         = 1'b0;
        we3         = 1'b0;
        re1         = 1'b0;
        re2         = 1'b0;
        re3         = 1'b0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_cnt1 < MAX_CNT) begin
                        we1    = 1'b1;
                        n_cnt1 = r_cnt1 + CW'(1);
                    end
                    if (i_final_job) begin
                        n_state = ST_READ;
                        n_level = LVL_ONE;
                        n_idx   = '0;
                    end
                end
            end
            ST_READ: begin
                if (r_idx < cur_cnt) begin
                    re1     = (r_level == LVL_ONE);
                    re2     = (r_level == LVL_TWO);
                    re3     = (r_level == LVL_THREE);
                    n_state = ST_EXEC;
                end else if (r_level == LVL_THREE) begin
                    // Set complete: clear it for the next one.
                    n_cnt1    = '0;
                    n_cnt2    = '0;
                    n_cnt3    = '0;
                    n_done    = '0;
                    n_elapsed = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_level = r_level + LEVEL_W'(1);
                    n_idx   = '0;
                end
            end
            ST_EXEC: begin
                if (outlives) begin
                    // Run for the slice and drop one level.
                    n_elapsed = time_sum[ELAPSED_W-1:0];
                    if (r_level == LVL_ONE) begin
                        if (r_cnt2 < MAX_CNT) begin
                            we2    = 1'b1;
                            n_cnt2 = r_cnt2 + CW'(1);
                        end
                    end else begin
                        if (r_cnt3 < MAX_CNT) begin
                            we3    = 1'b1;
                            n_cnt3 = r_cnt3 + CW'(1);
                        end
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_READ;
                end else if (!r_out_valid || !i_out_stall) begin
                    // Job completes; wait here while the result register is held.
                    n_elapsed   = time_sum[ELAPSED_W-1:0];
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_done      = r_done + CW'(1);
                    n_idx       = r_idx + CW'(1);
                    n_state     = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= LVL_ONE;
            r_idx       <= '0;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_cnt3      <= '0;
            r_done      <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            r_slice1    <= SLICE_ONE_RST;
            r_slice2    <= SLICE_TWO_RST;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_idx       <= n_idx;
            r_cnt1      <= n_cnt1;
            r_cnt2      <= n_cnt2;
            r_cnt3      <= n_cnt3;
            r_done      <= n_done;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLICE_ONE: r_slice1 <= i_cfg_data;
                    CFG_SLICE_TWO: r_slice2 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_job_number   <= id_ext[JOB_NUM_W-1:0];
            r_finish_time  <= time_sum[ELAPSED_W-1:0];
            r_finish_level <= r_level;
            r_last_result  <= ((r_done + CW'(1)) == r_cnt1);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_job_number   = r_job_number;
    assign o_finish_time  = r_finish_time;
    assign o_finish_level = r_finish_level;
    assign o_last_result  = r_last_result;

endmodule

`default_nettype wire

/* rtl/core/mlfq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
